// File: src/rmau_pkg.sv
package rmau_pkg;

	localparam int unsigned MemCellsDefault = 256;
	localparam logic [31:0] EmptyMark = 32'h8000_0000;

	typedef enum logic [2:0] {
		MODE_LOAD  = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_SUB   = 3'd2,
		MODE_MULT  = 3'd3,
		MODE_DIV   = 3'd4,
		MODE_WRITE = 3'd5,
		MODE_STORE = 3'd6,
		MODE_NONE  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		AM_IMM = 2'd0,
		AM_DIR = 2'd1,
		AM_IND = 2'd2,
		AM_BAD = 2'd3
	} addr_mode_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_EMPTY_ACC     = 3'd1,
		ST_BAD_INDEX     = 3'd2,
		ST_BAD_ARG       = 3'd3,
		ST_DIV_ZERO      = 3'd4,
		ST_EMPTY_OPERAND = 3'd5
	} status_t;

	// Decoded instruction carried from the front end to the execute unit.
	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  addr_mode;
		logic [31:0] operand;
		logic [31:0] store_value;
		logic        idx_ok;   // operand is a cell number in 1..cells-1
	} instr_t;

	typedef enum logic [3:0] {
		EX_IDLE,
		EX_CLEAR,
		EX_DISPATCH,
		EX_RD1,
		EX_CHK1,
		EX_RD2,
		EX_CHK2,
		EX_ALU,
		EX_MUL,
		EX_DIV,
		EX_DIVFIX,
		EX_DONE
	} ex_state_t;

endpackage

// File: src/rmau_front.sv
module rmau_front #(
	parameter int unsigned MEM_CELLS = rmau_pkg::MemCellsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          mode,
	input  logic [1:0]          addr_mode,
	input  logic signed [31:0]  operand,
	input  logic signed [31:0]  store_value,
	output logic                q_valid,
	input  logic                q_ready,
	output rmau_pkg::instr_t    q_data
);
	import rmau_pkg::*;

	// Two-entry queue between front and back.
	instr_t     fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	instr_t     dec;
	logic       push, pop;

	always_comb begin
		dec.mode        = mode;
		dec.addr_mode   = addr_mode;
		dec.operand     = operand;
		dec.store_value = store_value;
		dec.idx_ok      = !operand[31] && (operand != 32'sd0)
			&& ({1'b0, operand} < 33'(MEM_CELLS));
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_data   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: src/rmau_exec.sv
module rmau_exec #(
	parameter int unsigned MEM_CELLS = rmau_pkg::MemCellsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  rmau_pkg::instr_t   q_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] acc_value,
	output logic               tape_valid,
	output logic signed [31:0] tape_value
);
	import rmau_pkg::*;

	localparam int unsigned AW = (MEM_CELLS > 2) ? $clog2(MEM_CELLS) : 1;

	logic [31:0]   mem [MEM_CELLS];
	ex_state_t     state_q, state_d;
	instr_t        ins_q;
	logic [31:0]   acc_q;
	logic [31:0]   rd_q;
	logic [AW-1:0] rd_addr, clr_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0]   mem_wd;
	logic [31:0]   val_q;
	logic [63:0]   prod_s1;
	// Divider: restoring, one quotient bit per cycle on magnitudes.
	logic [31:0]   dvd_q, dvs_q, quo_q;
	logic [32:0]   rem_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic [32:0]   trial;
	logic [2:0]    st_q;
	logic          tv_q;
	logic [31:0]   tval_q;
	logic          ptr_ok;
	logic          take;

	assign take = q_valid && q_ready;
	assign ptr_ok = !rd_q[31] && (rd_q != 32'd0) && ({1'b0, rd_q} < 33'(MEM_CELLS));
	assign trial = {rem_q[31:0], dvd_q[31]} - {1'b0, dvs_q};

	// Second read of an indirect fetch uses the pointer latched in val_q.
	always_comb begin
		rd_addr = ins_q.operand[AW-1:0];
		if (state_q == EX_RD2) rd_addr = val_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = EmptyMark;
		if (state_q == EX_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == EX_DISPATCH && ins_q.mode == MODE_STORE && ins_q.idx_ok) begin
			mem_we = 1'b1;
			mem_wa = ins_q.operand[AW-1:0];
			mem_wd = ins_q.store_value;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_CLEAR:    if (32'(clr_q) == MEM_CELLS - 1) state_d = EX_IDLE;
			EX_IDLE:     if (take) state_d = EX_DISPATCH;
			EX_DISPATCH: begin
				if (ins_q.mode == MODE_STORE || ins_q.mode == MODE_NONE) state_d = EX_DONE;
				else if (ins_q.mode >= MODE_ADD && ins_q.mode <= MODE_DIV && acc_q == EmptyMark)
					state_d = EX_DONE;
				else if (ins_q.addr_mode == AM_IMM)
					state_d = (ins_q.operand == EmptyMark) ? EX_DONE : EX_ALU;
				else if (ins_q.addr_mode == AM_BAD || !ins_q.idx_ok) state_d = EX_DONE;
				else state_d = EX_RD1;
			end
			EX_RD1:      state_d = EX_CHK1;
			EX_CHK1: begin
				if (rd_q == EmptyMark) state_d = EX_DONE;
				else if (ins_q.addr_mode == AM_DIR) state_d = EX_ALU;
				else if (!ptr_ok) state_d = EX_DONE;
				else state_d = EX_RD2;
			end
			EX_RD2:      state_d = EX_CHK2;
			EX_CHK2:     state_d = (rd_q == EmptyMark) ? EX_DONE : EX_ALU;
			EX_ALU: begin
				if (ins_q.mode == MODE_MULT) state_d = EX_MUL;
				else if (ins_q.mode == MODE_DIV && val_q != 32'd0) state_d = EX_DIV;
				else state_d = EX_DONE;
			end
			EX_MUL:      state_d = EX_DONE;
			EX_DIV:      if (cnt_q == 6'd31) state_d = EX_DIVFIX;
			EX_DIVFIX:   state_d = EX_DONE;
			EX_DONE:     if (out_ready) state_d = EX_IDLE;
			default:     state_d = EX_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = (state_q == EX_IDLE);
		out_valid = (state_q == EX_DONE);
	end

	assign status     = st_q;
	assign acc_value  = acc_q;
	assign tape_valid = tv_q;
	assign tape_value = tval_q;

	always_ff @(posedge clk) begin
		if (take) ins_q <= q_data;
		prod_s1 <= acc_q * val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_CLEAR;
			clr_q   <= '0;
			acc_q   <= EmptyMark;
			st_q    <= ST_OK;
			tv_q    <= 1'b0;
			tval_q  <= '0;
			val_q   <= '0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				EX_CLEAR: clr_q <= clr_q + AW'(1);
				EX_DISPATCH: begin
					st_q   <= ST_OK;
					tv_q   <= 1'b0;
					tval_q <= '0;
					val_q  <= ins_q.operand;
					if (ins_q.mode == MODE_STORE) begin
						if (!ins_q.idx_ok) st_q <= ST_BAD_INDEX;
					end else if (ins_q.mode == MODE_NONE) st_q <= ST_BAD_ARG;
					else if (ins_q.mode >= MODE_ADD && ins_q.mode <= MODE_DIV
							&& acc_q == EmptyMark) st_q <= ST_EMPTY_ACC;
					else if (ins_q.addr_mode == AM_IMM) begin
						if (ins_q.operand == EmptyMark) st_q <= ST_EMPTY_OPERAND;
					end else if (ins_q.addr_mode == AM_BAD) st_q <= ST_BAD_ARG;
					else if (!ins_q.idx_ok) st_q <= ST_BAD_INDEX;
				end
				EX_CHK1: begin
					val_q <= rd_q;
					if (rd_q == EmptyMark || (ins_q.addr_mode == AM_IND && !ptr_ok))
						st_q <= ST_BAD_INDEX;
				end
				EX_CHK2: begin
					val_q <= rd_q;
					if (rd_q == EmptyMark) st_q <= ST_BAD_INDEX;
				end
				EX_ALU: begin
					case (ins_q.mode)
						MODE_LOAD: acc_q <= val_q;
						MODE_ADD:  acc_q <= acc_q + val_q;
						MODE_SUB:  acc_q <= acc_q - val_q;
						MODE_DIV: begin
							if (val_q == 32'd0) st_q <= ST_DIV_ZERO;
							dvd_q <= acc_q[31] ? -acc_q : acc_q;
							dvs_q <= val_q[31] ? -val_q : val_q;
							neg_q <= acc_q[31] ^ val_q[31];
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= '0;
						end
						MODE_WRITE: begin
							tv_q   <= 1'b1;
							tval_q <= val_q;
						end
						default: ;
					endcase
				end
				EX_MUL: acc_q <= prod_s1[31:0];
				EX_DIV: begin
					if (!trial[32]) begin
						rem_q <= trial;
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], dvd_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
				end
				EX_DIVFIX: acc_q <= neg_q ? -quo_q : quo_q;
				default: ;
			endcase
		end
	end

endmodule

// File: src/ram_machine_accumulator_unit_core.sv
// Path, input to result transaction: through the front queue to dispatch; store and
//   early rejects finish there, rejects after a cell read at the check, load/add/sub/
//   write after the ALU state, mult after its product state, div after a 32-step restoring divider.
// Throughput: one transaction at a time in the execute unit; the front queue
//   holds two more. Each indirect operand costs two dependent memory reads.
// Reset: accumulator empty; a clearing pass writes the empty mark into all MEM_CELLS
//   cells of the memory before the first transaction is executed.
module ram_machine_accumulator_unit_core #(
	parameter int unsigned MEM_CELLS = rmau_pkg::MemCellsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [1:0]         addr_mode,
	input  logic signed [31:0] operand,
	input  logic signed [31:0] store_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] acc_value,
	output logic               tape_valid,
	output logic signed [31:0] tape_value
);
	import rmau_pkg::*;

	// Front: decode and range check, into a short queue.
	logic   q_valid, q_ready;
	instr_t q_data;

	rmau_front #(.MEM_CELLS(MEM_CELLS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .addr_mode, .operand,
		.store_value, .q_valid, .q_ready, .q_data
	);

	// Back: operand fetch, arithmetic, result register.
	rmau_exec #(.MEM_CELLS(MEM_CELLS)) u_exec (
		.clk, .arst_n, .q_valid, .q_ready, .q_data, .out_valid, .out_ready,
		.status, .acc_value, .tape_valid, .tape_value
	);

endmodule
